// ===== hw/rtl/nps2d_pkg.sv =====
`default_nettype none

package nps2d_pkg;

    localparam int COORD_W       = 16;
    localparam int RADIUS_W      = 16;
    localparam int ACTION_W      = 2;
    localparam int POINT_INDEX_W = 10;
    localparam int CFG_INDEX_W   = 2;
    localparam int SQ_W          = 2 * COORD_W;
    localparam int DIST_W        = 2 * COORD_W + 1;
    localparam int R2_W          = 2 * RADIUS_W;

    localparam int DEF_CAPACITY = 1024;

    localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_NEAREST = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RANGE   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOTTOM = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP    = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [RADIUS_W-1:0]       radius;
    } in_item_t;

    typedef struct packed {
        logic                      accepted;
        logic                      found;
        logic [POINT_INDEX_W-1:0]  point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nearest_point_store_2d_unit.sv =====
`default_nettype none

// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  nps2d_pkg::in_item_t
// m_        out        m_valid / m_ready  nps2d_pkg::out_item_t
// cfg_      in         cfg_we             cfg_index, cfg_data
//
// Insert, unused action and range outside the map skip the scan and go straight to the response state.
// Other queries scan one entry per cycle through a read / difference / square /
// compare pipeline. The result is registered from the response state once the output is free.
// Reset clears the point count and restores the full-range map edges.
// One item is in work at a time; a held result does not block the next transfer.

module nearest_point_store_2d_unit #(
    parameter int CAPACITY = nps2d_pkg::DEF_CAPACITY
) (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    input  wire                                       s_valid,
    output logic                                      s_ready,
    input  nps2d_pkg::in_item_t                       s_data,
    output logic                                      m_valid,
    input  wire                                       m_ready,
    output nps2d_pkg::out_item_t                      m_data,
    input  wire                                       cfg_we,
    input  wire [nps2d_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  wire [nps2d_pkg::COORD_W-1:0]              cfg_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = nps2d_pkg::COORD_W;
    localparam int PIW   = nps2d_pkg::POINT_INDEX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg, state_next;

    logic signed [CW-1:0] left_reg, right_reg, bottom_reg, top_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     addr_reg;

    logic [2*CW-1:0] mem [CAPACITY];
    logic [2*CW-1:0] rd_data_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic signed [CW-1:0] px2_reg, py2_reg, px3_reg, py3_reg;
    logic [CW-1:0] dx_reg, dy_reg;
    logic [nps2d_pkg::SQ_W-1:0] sqx_reg, sqy_reg;

    logic [nps2d_pkg::ACTION_W-1:0] act_reg;
    logic signed [CW-1:0]           qx_reg, qy_reg;
    logic [nps2d_pkg::R2_W-1:0]     r2_reg;
    logic [nps2d_pkg::DIST_W-1:0]   best_dist_reg;

    logic                 res_acc_reg, res_found_reg;
    logic [PIW-1:0]       res_index_reg;
    logic signed [CW-1:0] res_x_reg, res_y_reg;

    logic                 out_valid_reg;
    nps2d_pkg::out_item_t out_reg;

    logic s_fire, in_inside, ins_ok, issue, out_free, scan_done;
    logic [IDX_W+PIW-1:0] ins_index_wide, best_index_wide;
    logic signed [CW:0] diff_x, diff_y;
    logic [nps2d_pkg::DIST_W-1:0] dist_sum;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    assign in_inside = (s_data.coord_x >= left_reg) && (s_data.coord_x <= right_reg)
                    && (s_data.coord_y >= bottom_reg) && (s_data.coord_y <= top_reg);
    assign ins_ok    = in_inside && (count_reg < CNT_W'(CAPACITY));

    assign issue     = (state_reg == ST_SCAN) && (addr_reg < count_reg);
    assign scan_done = !issue && !v1_reg && !v2_reg && !v3_reg;

    assign ins_index_wide  = {{PIW{1'b0}}, count_reg[IDX_W-1:0]};
    assign best_index_wide = {{PIW{1'b0}}, idx3_reg};

    assign diff_x   = {rd_data_reg[2*CW-1], rd_data_reg[2*CW-1:CW]} - {qx_reg[CW-1], qx_reg};
    assign diff_y   = {rd_data_reg[CW-1], rd_data_reg[CW-1:0]} - {qy_reg[CW-1], qy_reg};
    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_data.action)
                        nps2d_pkg::ACT_NEAREST: state_next = ST_SCAN;
                        nps2d_pkg::ACT_RANGE:   state_next = in_inside ? ST_SCAN : ST_RESP;
                        default:                state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= {1'b1, {(CW-1){1'b0}}};
            right_reg     <= {1'b0, {(CW-1){1'b1}}};
            bottom_reg    <= {1'b1, {(CW-1){1'b0}}};
            top_reg       <= {1'b0, {(CW-1){1'b1}}};
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    nps2d_pkg::CFG_LEFT:   left_reg   <= cfg_data;
                    nps2d_pkg::CFG_RIGHT:  right_reg  <= cfg_data;
                    nps2d_pkg::CFG_BOTTOM: bottom_reg <= cfg_data;
                    nps2d_pkg::CFG_TOP:    top_reg    <= cfg_data;
                    default: ;
                endcase
            end

            if (s_fire && s_data.action == nps2d_pkg::ACT_INSERT && ins_ok) begin
                count_reg <= count_reg + 1'b1;
            end

            if (s_fire) begin
                addr_reg <= '0;
            end else if (issue) begin
                addr_reg <= addr_reg + 1'b1;
            end

            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            if (state_reg == ST_RESP && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // point memory and scan datapath
    always_ff @(posedge aclk) begin
        if (s_fire && s_data.action == nps2d_pkg::ACT_INSERT && ins_ok) begin
            mem[count_reg[IDX_W-1:0]] <= {s_data.coord_x, s_data.coord_y};
        end
        if (issue) begin
            rd_data_reg <= mem[addr_reg[IDX_W-1:0]];
            idx1_reg    <= addr_reg[IDX_W-1:0];
        end

        idx2_reg <= idx1_reg;
        px2_reg  <= rd_data_reg[2*CW-1:CW];
        py2_reg  <= rd_data_reg[CW-1:0];
        dx_reg   <= diff_x[CW] ? CW'(-diff_x) : CW'(diff_x);
        dy_reg   <= diff_y[CW] ? CW'(-diff_y) : CW'(diff_y);

        idx3_reg <= idx2_reg;
        px3_reg  <= px2_reg;
        py3_reg  <= py2_reg;
        sqx_reg  <= dx_reg * dx_reg;
        sqy_reg  <= dy_reg * dy_reg;
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            act_reg       <= s_data.action;
            qx_reg        <= s_data.coord_x;
            qy_reg        <= s_data.coord_y;
            r2_reg        <= s_data.radius * s_data.radius;
            res_found_reg <= 1'b0;
            res_x_reg     <= '0;
            res_y_reg     <= '0;
            res_index_reg <= '0;
            case (s_data.action)
                nps2d_pkg::ACT_INSERT: begin
                    res_acc_reg <= ins_ok;
                    if (ins_ok) begin
                        res_index_reg <= ins_index_wide[PIW-1:0];
                    end
                end
                nps2d_pkg::ACT_NEAREST, nps2d_pkg::ACT_RANGE: res_acc_reg <= in_inside;
                default: res_acc_reg <= 1'b0;
            endcase
        end else if (v3_reg) begin
            if (act_reg == nps2d_pkg::ACT_NEAREST) begin
                // strict less keeps the earliest point on ties
                if (!res_found_reg || dist_sum < best_dist_reg) begin
                    best_dist_reg <= dist_sum;
                    res_found_reg <= 1'b1;
                    res_index_reg <= best_index_wide[PIW-1:0];
                    res_x_reg     <= px3_reg;
                    res_y_reg     <= py3_reg;
                end
            end else if (dist_sum < {1'b0, r2_reg}) begin
                res_found_reg <= 1'b1;
            end
        end

        if (state_reg == ST_RESP && out_free) begin
            out_reg.accepted    <= res_acc_reg;
            out_reg.found       <= res_found_reg;
            out_reg.point_index <= res_index_reg;
            out_reg.point_x     <= res_x_reg;
            out_reg.point_y     <= res_y_reg;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import nps2d_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int CAP         = DEF_CAPACITY;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int SHOW_LIMIT  = 100;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    in_item_t                 s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    out_item_t                m_data;
    logic                     cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = CFG_LEFT;
    logic [COORD_W-1:0]       cfg_data  = '0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    nearest_point_store_2d_unit #(.CAPACITY(CAP)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the point store and map edges
    logic signed [COORD_W-1:0] store_x [CAP];
    logic signed [COORD_W-1:0] store_y [CAP];
    int                        stored_count = 0;
    logic signed [COORD_W-1:0] map_left   = -16'sd32768;
    logic signed [COORD_W-1:0] map_right  = 16'sd32767;
    logic signed [COORD_W-1:0] map_bottom = -16'sd32768;
    logic signed [COORD_W-1:0] map_top    = 16'sd32767;

    in_item_t                  queued_items [$];
    out_item_t                 owed_answers [$];
    logic signed [COORD_W-1:0] hint_x [$];
    logic signed [COORD_W-1:0] hint_y [$];

    logic s_taken = 1'b0;
    logic m_taken = 1'b0;
    int   tx_wait = 0, tx_calm = 0;
    int   rx_wait = 0, rx_calm = 0;
    logic hold_req = 1'b0, hold_done = 1'b0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   error_count = 0;
    int   checked_count = 0;
    int   map_settings = 1;
    int   sent_by_action [4] = '{0, 0, 0, 0};

    function automatic int next_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) calm_left = $urandom_range(8, 40);
        return $urandom_range(0, 6);
    endfunction

    function automatic logic within_map(logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y);
        return map_left <= x && x <= map_right && map_bottom <= y && y <= map_top;
    endfunction

    function automatic longint dist_sq(int slot, logic signed [COORD_W-1:0] x,
                                       logic signed [COORD_W-1:0] y);
        longint dx, dy;
        dx = longint'(store_x[slot]) - longint'(x);
        dy = longint'(store_y[slot]) - longint'(y);
        return dx * dx + dy * dy;
    endfunction

    function automatic out_item_t answer_for(in_item_t it);
        out_item_t res;
        logic      in_map;
        longint    d2, best_d2, r2;
        int        best;
        res     = '0;
        in_map  = within_map(it.coord_x, it.coord_y);
        best    = 0;
        best_d2 = 0;
        case (it.action)
            ACT_INSERT: begin
                if (in_map && stored_count < CAP) begin
                    store_x[stored_count] = it.coord_x;
                    store_y[stored_count] = it.coord_y;
                    res.accepted    = 1'b1;
                    res.point_index = POINT_INDEX_W'(stored_count);
                    stored_count++;
                end
            end
            ACT_NEAREST: begin
                res.accepted = in_map;
                for (int i = 0; i < stored_count; i++) begin
                    d2 = dist_sq(i, it.coord_x, it.coord_y);
                    if (i == 0 || d2 < best_d2) begin
                        best    = i;
                        best_d2 = d2;
                    end
                end
                if (stored_count > 0) begin
                    res.found       = 1'b1;
                    res.point_index = POINT_INDEX_W'(best);
                    res.point_x     = store_x[best];
                    res.point_y     = store_y[best];
                end
            end
            ACT_RANGE: begin
                if (in_map) begin
                    res.accepted = 1'b1;
                    r2 = longint'(it.radius) * longint'(it.radius);
                    for (int i = 0; i < stored_count; i++) begin
                        if (dist_sq(i, it.coord_x, it.coord_y) < r2) res.found = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // transfers, prediction, checking, watchdog
    always @(posedge aclk) begin
        out_item_t want;
        s_taken <= aresetn && s_valid && s_ready;
        m_taken <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            owed_answers = {owed_answers, answer_for(s_data)};
            sent_by_action[s_data.action]++;
        end
        if (aresetn && m_valid && m_ready) begin
            checked_count++;
            if (owed_answers.size() == 0) begin
                error_count++;
                if (error_count <= SHOW_LIMIT)
                    $display("%0t: unexpected result: expected none, actual %p",
                             $time, m_data);
            end else begin
                want = owed_answers.pop_front();
                if (m_data.accepted !== want.accepted || m_data.found !== want.found ||
                    m_data.point_index !== want.point_index ||
                    m_data.point_x !== want.point_x || m_data.point_y !== want.point_y) begin
                    error_count++;
                    if (error_count <= SHOW_LIMIT)
                        $display("%0t: mismatch: expected %p, actual %p",
                                 $time, want, m_data);
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, owed_answers.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_taken) begin
        end else if (tx_wait > 0) begin
            s_valid <= 1'b0;
            tx_wait--;
        end else if (queued_items.size() != 0) begin
            s_data  <= queued_items.pop_front();
            s_valid <= 1'b1;
            tx_wait = next_wait(tx_calm);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (m_taken) rx_wait = next_wait(rx_calm);
            if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_item(logic [ACTION_W-1:0] act, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, logic [RADIUS_W-1:0] r);
        in_item_t it;
        it.action  = act;
        it.coord_x = x;
        it.coord_y = y;
        it.radius  = r;
        queued_items = {queued_items, it};
        if (act == ACT_INSERT) begin
            hint_x = {hint_x, x};
            hint_y = {hint_y, y};
        end
    endtask

    // biased toward the map edges, inside the map, and anywhere
    function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] lo,
                                                             logic signed [COORD_W-1:0] hi);
        int v;
        case ($urandom_range(0, 7))
            0, 1:    v = int'(lo) + int'($urandom_range(0, 4)) - 2;
            2, 3:    v = int'(hi) + int'($urandom_range(0, 4)) - 2;
            4, 5:    v = (lo <= hi) ? int'(lo) + int'($urandom_range(0, int'(hi) - int'(lo)))
                                    : int'($urandom);
            default: v = int'($urandom);
        endcase
        return COORD_W'(v);
    endfunction

    task automatic push_random(int n, logic signed [COORD_W-1:0] lx,
                               logic signed [COORD_W-1:0] rx,
                               logic signed [COORD_W-1:0] by,
                               logic signed [COORD_W-1:0] ty);
        logic [ACTION_W-1:0]       act;
        logic signed [COORD_W-1:0] x, y;
        logic [RADIUS_W-1:0]       r;
        int                        pick, k, off;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            act  = pick < 36 ? ACT_INSERT : pick < 66 ? ACT_NEAREST :
                   pick < 95 ? ACT_RANGE : ACT_NONE;
            x = pick_coord(lx, rx);
            y = pick_coord(by, ty);
            if (hint_x.size() != 0 && $urandom_range(0, 3) == 0) begin
                k   = $urandom_range(0, hint_x.size() - 1);
                off = (act == ACT_INSERT) ? 0 : int'($urandom_range(0, 6)) - 3;
                x   = COORD_W'(int'(hint_x[k]) + off);
                y   = COORD_W'(int'(hint_y[k]) - off);
            end
            case ($urandom_range(0, 5))
                0:       r = '0;
                1:       r = RADIUS_W'($urandom_range(1, 8));
                2, 3:    r = RADIUS_W'($urandom_range(0, 3000));
                4:       r = '1;
                default: r = RADIUS_W'($urandom);
            endcase
            push_item(act, x, y, r);
        end
    endtask

    task automatic wait_drained();
        while (queued_items.size() != 0 || s_valid || owed_answers.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [COORD_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic set_edges(logic signed [COORD_W-1:0] l, logic signed [COORD_W-1:0] r,
                             logic signed [COORD_W-1:0] b, logic signed [COORD_W-1:0] t);
        write_reg(CFG_LEFT, l);
        write_reg(CFG_RIGHT, r);
        write_reg(CFG_BOTTOM, b);
        write_reg(CFG_TOP, t);
        @(negedge aclk);
        cfg_we     <= 1'b0;
        map_left   = l;
        map_right  = r;
        map_bottom = b;
        map_top    = t;
        map_settings++;
    endtask

    initial begin
        logic signed [COORD_W-1:0] ra, rb, rc, rd;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty store, corners, duplicates, equal-distance ties, strict radius
        push_item(ACT_NEAREST, 0, 0, 0);
        push_item(ACT_RANGE, 5, 5, 16'hFFFF);
        push_item(ACT_NONE, -1, -1, 16'hFFFF);
        push_item(ACT_INSERT, -32768, -32768, 0);
        push_item(ACT_INSERT, 32767, 32767, 0);
        push_item(ACT_INSERT, 32767, -32768, 0);
        push_item(ACT_INSERT, -32768, 32767, 0);
        push_item(ACT_INSERT, 0, 0, 0);
        push_item(ACT_INSERT, 0, 0, 0);
        push_item(ACT_INSERT, 0, 10, 0);
        push_item(ACT_NEAREST, 0, 5, 0);
        push_item(ACT_NEAREST, 1, 1, 0);
        push_item(ACT_NEAREST, -32768, -32768, 0);
        push_item(ACT_NEAREST, 32767, 32767, 0);
        push_item(ACT_RANGE, 0, 0, 0);
        push_item(ACT_RANGE, 10, 0, 10);
        push_item(ACT_RANGE, 10, 0, 11);
        push_item(ACT_RANGE, -32768, 32767, 16'hFFFF);
        push_item(ACT_RANGE, 16000, -16000, 1);
        push_item(ACT_NONE, 0, 0, 0);
        push_item(ACT_NEAREST, -32768, 0, 0);
        push_item(ACT_RANGE, 32767, 0, 16'hFFFF);
        wait_drained();

        // result side stalls long enough to back up the input
        push_random(170, -32768, 32767, -32768, 32767);
        hold_req = 1'b1;
        wait_drained();

        set_edges(-1000, 1000, -500, 500);
        push_random(110, -1000, 1000, -500, 500);
        wait_drained();
        set_edges(100, -100, -32768, 32767);
        push_random(40, 100, -100, -32768, 32767);
        wait_drained();
        set_edges(-32768, 32767, 5, -5);
        push_random(40, -32768, 32767, 5, -5);
        wait_drained();
        set_edges(32767, 32767, -32768, -32768);
        push_random(30, 32767, 32767, -32768, -32768);
        wait_drained();
        set_edges(-32768, -32768, 32767, 32767);
        push_random(30, -32768, -32768, 32767, 32767);
        repeat (2) begin
            wait_drained();
            ra = COORD_W'($urandom);
            rb = COORD_W'($urandom);
            rc = COORD_W'($urandom);
            rd = COORD_W'($urandom);
            set_edges(ra < rb ? ra : rb, ra < rb ? rb : ra, rc < rd ? rc : rd, rc < rd ? rd : rc);
            push_random(65, map_left, map_right, map_bottom, map_top);
        end
        wait_drained();

        // full map again, then queries over every stored point
        set_edges(-32768, 32767, -32768, 32767);
        push_item(ACT_INSERT, 0, 0, 0);
        push_item(ACT_INSERT, 32767, -32768, 16'hFFFF);
        repeat (3)
            push_item(ACT_NEAREST, COORD_W'($urandom), COORD_W'($urandom), RADIUS_W'($urandom));
        push_item(ACT_NEAREST, -32768, 32767, 0);
        repeat (3)
            push_item(ACT_RANGE, COORD_W'($urandom), COORD_W'($urandom),
                      RADIUS_W'($urandom_range(0, 400)));
        push_item(ACT_RANGE, 0, 0, 16'hFFFF);
        push_item(ACT_NONE, COORD_W'($urandom), COORD_W'($urandom), RADIUS_W'($urandom));
        wait_drained();
        repeat (40) @(posedge aclk);

        $display("Covered %0d inserts, %0d nearest, %0d range, %0d unused-code transfers,",
                 sent_by_action[ACT_INSERT], sent_by_action[ACT_NEAREST],
                 sent_by_action[ACT_RANGE], sent_by_action[ACT_NONE]);
        $display("%0d results, %0d maps incl. inverted and one-point, %0d of %0d points stored.",
                 checked_count, map_settings, stored_count, CAP);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
